// ----- sv/elf_hash_bucket_index_defines.svh -----
// Assertion macros shared by the hash bucket index modules
`ifndef ELF_HASH_BUCKET_INDEX_DEFINES_SVH
`define ELF_HASH_BUCKET_INDEX_DEFINES_SVH

`ifndef SYNTH

`define ELFH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ELFH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ELFH_ASSERT_IMP(lbl, ante, cons, msg)

`define ELFH_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- sv/elfh_pkg.sv -----
// Shared widths, defaults and types for the hash bucket index block
package elfh_pkg;

    localparam int HASH_W      = 28;
    localparam int BUCKET_W    = 24;
    localparam int BYTE_W      = 8;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- sv/elfh_front.sv -----
// Front end: accept key bytes and keep the running hash per key
module elfh_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [elfh_pkg::BYTE_W-1:0]  in_byte,
    input  logic                         in_present,
    input  logic                         in_last,
    input  elfh_pkg::q_status_t          q_status,
    output logic                         push,
    output logic [elfh_pkg::HASH_W-1:0]  push_hash
);

    localparam int SUM_W = elfh_pkg::HASH_W + 4;

    logic [elfh_pkg::HASH_W-1:0] hash_reg;
    logic [elfh_pkg::HASH_W-1:0] hash_next;
    logic [elfh_pkg::HASH_W-1:0] mixed;
    logic [SUM_W-1:0]            sum;
    logic [3:0]                  top;
    logic                        accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        sum   = {hash_reg, 4'b0000}
              + {{(SUM_W - elfh_pkg::BYTE_W){in_byte[elfh_pkg::BYTE_W-1]}}, in_byte};
        top   = sum[SUM_W-1 -: 4];
        mixed = in_present
              ? (sum[elfh_pkg::HASH_W-1:0]
                 ^ {{(elfh_pkg::HASH_W - 8){1'b0}}, top, 4'b0000})
              : hash_reg;
    end

    always_comb
    begin
        hash_next = hash_reg;
        if (accept)
        begin
            hash_next = in_last ? '0 : mixed;
        end
    end

    assign push      = accept && in_last;
    assign push_hash = mixed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

endmodule

// ----- sv/elfh_queue.sv -----
// Short queue of finished key hashes between front and back end
`include "elf_hash_bucket_index_defines.svh"

module elfh_queue
#(
    parameter int DEPTH = elfh_pkg::QUEUE_DEPTH,
    parameter int WIDTH = elfh_pkg::HASH_W
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    push_data,
    input  logic                pop,
    output logic [WIDTH-1:0]    pop_data,
    output elfh_pkg::q_status_t status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ELFH_ASSERT_IMP(a_no_push_full, push, !status.full, "push into full queue")
    `ELFH_ASSERT_IMP(a_no_pop_empty, pop, !status.empty, "pop from empty queue")

endmodule

// ----- sv/elfh_back.sv -----
// Back end: reduce each key hash modulo the bucket count, one bit per cycle
`include "elf_hash_bucket_index_defines.svh"

module elfh_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  elfh_pkg::q_status_t           q_status,
    input  logic [elfh_pkg::HASH_W-1:0]   q_hash,
    output logic                          pop,
    input  logic [elfh_pkg::BUCKET_W-1:0] bucket_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [elfh_pkg::HASH_W-1:0]   out_hash,
    output logic [elfh_pkg::BUCKET_W-1:0] out_index
);

    localparam int HW    = elfh_pkg::HASH_W;
    localparam int BW    = elfh_pkg::BUCKET_W;
    localparam int CNT_W = $clog2(HW);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [HW-1:0]    hash_reg;
    logic [HW-1:0]    hash_next;
    logic [HW-1:0]    dvd_reg;
    logic [HW-1:0]    dvd_next;
    logic [BW-1:0]    div_reg;
    logic [BW-1:0]    div_next;
    logic [BW-1:0]    rem_reg;
    logic [BW-1:0]    rem_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [HW-1:0]    out_hash_reg;
    logic [HW-1:0]    out_hash_next;
    logic [BW-1:0]    out_index_reg;
    logic [BW-1:0]    out_index_next;
    logic [BW:0]      rem_shift;
    logic [BW+1:0]    diff;
    logic             handoff;

    assign pop       = (state_reg == S_IDLE) && !q_status.empty;
    assign handoff   = (state_reg == S_WAIT) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_hash  = out_hash_reg;
    assign out_index = out_index_reg;

    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[HW-1]};
        diff      = {1'b0, rem_shift} - {2'b00, div_reg};
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        hash_next      = hash_reg;
        dvd_next       = dvd_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg;
        out_hash_next  = out_hash_reg;
        out_index_next = out_index_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    hash_next  = q_hash;
                    dvd_next   = q_hash;
                    div_next   = bucket_count;
                    rem_next   = '0;
                    cnt_next   = CNT_W'(HW - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = diff[BW+1] ? rem_shift[BW-1:0] : diff[BW-1:0];
                dvd_next = {dvd_reg[HW-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (handoff)
                begin
                    out_valid_next = 1'b1;
                    out_hash_next  = hash_reg;
                    out_index_next = (div_reg == '0) ? '0 : rem_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        hash_reg      <= hash_next;
        dvd_reg       <= dvd_next;
        div_reg       <= div_next;
        rem_reg       <= rem_next;
        out_hash_reg  <= out_hash_next;
        out_index_reg <= out_index_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ELFH_ASSERT_IMP(a_rem_below_div, (state_reg == S_DIV) && (div_reg != '0), rem_reg < div_reg, "remainder not below divisor")
    `ELFH_ASSERT_NXT(a_handoff_valid, handoff, out_valid_reg, "handoff did not raise output valid")

endmodule

// ----- sv/elf_hash_bucket_index.sv -----
// Top level of the ELF hash bucket index block with its register port
// Key bytes stream in one per transaction with tlast on the final byte and tuser set when
// the byte belongs to the key; a transaction with tuser low and tlast high ends a key
// (an empty key hashes to 0). The front end takes one byte every cycle while the hash
// queue has room and finishes a key hash in the cycle its last byte arrives. The back end
// works on one key at a time: it pops the queue, runs a one-bit-per-step restoring
// division by bucket_count, then loads the output register, so short keys are limited
// by that divider and the queue absorbs bursts of short keys.
// Each result carries the 28-bit hash and the hash modulo bucket_count (0 when
// bucket_count is 0); write bucket_count at address 0 only while no key is in flight.
module elf_hash_bucket_index
#(
    parameter int QUEUE_DEPTH = elfh_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] key_byte
    input  logic        s_axis_tuser,  // [0] byte_present
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // [27:0] raw_hash, [51:28] bucket_index, [55:52] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int HW = elfh_pkg::HASH_W;
    localparam int BW = elfh_pkg::BUCKET_W;
    localparam logic REG_BUCKET_COUNT = 1'b0;

    logic [BW-1:0]       bucket_count_reg;
    logic [BW-1:0]       bucket_count_next;
    elfh_pkg::q_status_t q_status;
    logic                push;
    logic [HW-1:0]       push_hash;
    logic                pop;
    logic [HW-1:0]       pop_hash;
    logic [HW-1:0]       out_hash;
    logic [BW-1:0]       out_index;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BUCKET_COUNT) ? {{(32 - BW){1'b0}}, bucket_count_reg}
                                                  : '0;

    always_comb
    begin
        bucket_count_next = bucket_count_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_BUCKET_COUNT))
        begin
            bucket_count_next = pwdata[BW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= '0;
        end
        else
        begin
            bucket_count_reg <= bucket_count_next;
        end
    end

    elfh_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_present (s_axis_tuser),
        .in_last    (s_axis_tlast),
        .q_status   (q_status),
        .push       (push),
        .push_hash  (push_hash)
    );

    elfh_queue
    #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (HW)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_hash),
        .pop       (pop),
        .pop_data  (pop_hash),
        .status    (q_status)
    );

    elfh_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .q_hash       (pop_hash),
        .pop          (pop),
        .bucket_count (bucket_count_reg),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_hash     (out_hash),
        .out_index    (out_index)
    );

    assign m_axis_tdata = {{(56 - HW - BW){1'b0}}, out_index, out_hash};

endmodule

// ----- test/tb_elf_hash_bucket_index.sv -----
// Testbench for elf_hash_bucket_index: streams keys, predicts hashes and bucket indexes, checks results
`timescale 1ns / 100ps

module tb_elf_hash_bucket_index;

    localparam int         HASH_W            = elfh_pkg::HASH_W;
    localparam int         BUCKET_W          = elfh_pkg::BUCKET_W;
    localparam logic [2:0] BUCKET_COUNT_ADDR = 3'd0;
    localparam int         BYTE_SHIFT        = 4;
    localparam int         FOLD_SHIFT        = 24;
    localparam logic [31:0] TOP_NIBBLE       = 32'hF000_0000;
    localparam int         SETTLE_CYCLES     = 40;
    localparam int         IDLE_LIMIT        = 2000;
    localparam int         PHASE_ITEMS       = 285;
    localparam int         PHASE_COUNT       = 7;

    typedef struct packed {
        logic [HASH_W-1:0]   raw_hash;
        logic [BUCKET_W-1:0] bucket_index;
    } hash_result_t;

    class bucket_scoreboard;
        logic [HASH_W-1:0]   running_hash;
        logic [BUCKET_W-1:0] bucket_count;
        hash_result_t        pending_results[$];
        int                  errors;

        function new();
            running_hash = '0;
            bucket_count = '0;
            errors       = 0;
        endfunction

        function void set_bucket_count(logic [BUCKET_W-1:0] count);
            bucket_count = count;
        endfunction

        function void note_key_item(logic [7:0] key_byte, logic present, logic last);
            logic [31:0]  h;
            logic [31:0]  top;
            hash_result_t res;
            if (present)
            begin
                h = ({4'b0, running_hash} << BYTE_SHIFT) + {{24{key_byte[7]}}, key_byte};
                top = h & TOP_NIBBLE;
                if (top != 32'd0)
                    h = h ^ (top >> FOLD_SHIFT) ^ top;
                running_hash = h[HASH_W-1:0];
            end
            if (last)
            begin
                res.raw_hash = running_hash;
                if (bucket_count == '0)
                    res.bucket_index = '0;
                else
                    res.bucket_index = BUCKET_W'(32'(running_hash) % 32'(bucket_count));
                pending_results.push_back(res);
                running_hash = '0;
            end
        endfunction

        function void check_result(logic [55:0] data);
            hash_result_t expd;
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: actual %h", $time, data);
                errors++;
                return;
            end
            expd = pending_results.pop_front();
            if (data[HASH_W-1:0] !== expd.raw_hash)
            begin
                $display("%0t raw_hash mismatch: expected %h actual %h",
                         $time, expd.raw_hash, data[HASH_W-1:0]);
                errors++;
            end
            if (data[HASH_W+BUCKET_W-1:HASH_W] !== expd.bucket_index)
            begin
                $display("%0t bucket_index mismatch: expected %h actual %h",
                         $time, expd.bucket_index, data[HASH_W+BUCKET_W-1:HASH_W]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] key_byte
    logic        s_axis_tuser  = 1'b0;   // [0] byte_present
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;           // [27:0] raw_hash, [51:28] bucket_index, [55:52] zero
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = 3'd0;
    logic [31:0] pwdata        = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    bucket_scoreboard sb = new();

    bit idle_off     = 1'b0;
    int stall_left   = 0;
    int ready_roll   = 0;
    int idle_cycles  = 0;

    elf_hash_bucket_index DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receive results and drive back-pressure
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if (idle_off)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 65)
                m_axis_tready <= 1'b1;
            else if (ready_roll < 95)
            begin
                m_axis_tready <= 1'b0;
                stall_left <= $urandom_range(0, 3);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                stall_left <= $urandom_range(15, 60);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_elf_hash_bucket_index: FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        if (idle_off)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_key_item(input logic [7:0] key_byte, input logic present,
                                 input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key_byte;
        s_axis_tuser  <= present;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_key_item(key_byte, present, last);
    endtask

    task automatic send_random_key(output int sent);
        int  len;
        int  roll;
        bit  end_blank;
        sent = 0;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            len = 0;
        else if (roll < 75)
            len = $urandom_range(1, 8);
        else if (roll < 95)
            len = $urandom_range(9, 24);
        else
            len = $urandom_range(25, 64);
        end_blank = (len == 0) || ($urandom_range(0, 4) == 0);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < 6)
                send_key_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_key_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !end_blank);
            sent++;
        end
        if (end_blank)
        begin
            send_key_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            sent++;
        end
    endtask

    task automatic write_bucket_count(input logic [BUCKET_W-1:0] count);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BUCKET_COUNT_ADDR;
        pwdata  <= {8'd0, count};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_bucket_count(count);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [BUCKET_W-1:0] phase_counts [PHASE_COUNT];
        int                  sent;
        int                  phase_items;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero bucket count from reset
        send_key_item(8'hA5, 1'b0, 1'b1);
        send_key_item(8'h00, 1'b1, 1'b1);
        send_key_item(8'hFF, 1'b1, 1'b1);
        send_key_item(8'h80, 1'b1, 1'b1);
        send_key_item(8'h7F, 1'b1, 1'b1);
        for (int i = 0; i < 4; i++)
            send_key_item(8'h41 + 8'(i), 1'b1, 1'b0);
        send_key_item(8'h5A, 1'b0, 1'b0);
        for (int i = 4; i < 8; i++)
            send_key_item(8'h41 + 8'(i), 1'b1, 1'b0);
        send_key_item(8'hC3, 1'b0, 1'b1);
        for (int i = 0; i < 7; i++)
            send_key_item(8'hFF, 1'b1, i == 6);
        for (int i = 0; i < 3; i++)
            send_key_item(8'h7F, 1'b1, 1'b0);
        send_key_item(8'h80, 1'b1, 1'b1);
        drain_results();

        phase_counts[0] = 24'd1;
        phase_counts[1] = 24'hFFFFFF;
        phase_counts[2] = 24'd0;
        phase_counts[3] = 24'd2;
        phase_counts[4] = 24'd251;
        phase_counts[5] = 24'($urandom_range(1, 24'hFFFFFF));
        phase_counts[6] = 24'($urandom_range(3, 1000));

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_bucket_count(phase_counts[p]);
            idle_off = (p == 2) || (p == 5);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                send_random_key(sent);
                phase_items += sent;
            end
            drain_results();
        end

        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("tb_elf_hash_bucket_index: PASS");
        else
            $display("tb_elf_hash_bucket_index: FAIL");
        $finish;
    end

endmodule
